// File: hw/rtl/tpm_pkg.sv
// Shared constants, types and coefficient ROM of the true-peak meter.
package tpm_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_BITS      = 18;
  localparam int TAPS_PER_PHASE = 12;
  localparam int PHASES         = 4;
  localparam int CHANNELS       = 2;
  localparam int COEF_FRAC      = COEF_BITS - 2;
  localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS       = PROD_BITS + $clog2(TAPS_PER_PHASE);
  localparam int GROUP_TAPS     = 4;
  localparam int NGROUPS        = (TAPS_PER_PHASE + GROUP_TAPS - 1) / GROUP_TAPS;
  localparam int LANE_STAGES    = 4;

  typedef logic signed [SAMPLE_BITS-1:0] tpm_sample_t;
  typedef logic signed [COEF_BITS-1:0]   tpm_coef_t;
  typedef logic signed [PROD_BITS-1:0]   tpm_prod_t;
  typedef logic signed [ACC_BITS-1:0]    tpm_acc_t;
  typedef logic [SAMPLE_BITS-1:0]        tpm_mag_t;
  typedef logic [0:0]                    tpm_kind_t;

  typedef enum logic [0:0] {
    KIND_FRAME  = 1'b0,
    KIND_FINISH = 1'b1
  } tpm_kind_e;

  typedef tpm_coef_t tpm_coef_row_t [TAPS_PER_PHASE];

  localparam logic [ACC_BITS-1:0] ROUND_HALF    = ACC_BITS'(1) << (COEF_FRAC - 1);
  localparam logic [ACC_BITS-1:0] ROUND_HALF_UP = ROUND_HALF + ACC_BITS'(1);

  localparam tpm_coef_row_t COEF_TABLE [PHASES] = '{
    '{tpm_coef_t'(0), tpm_coef_t'(368), tpm_coef_t'(-1742), tpm_coef_t'(4767),
      tpm_coef_t'(-11510), tpm_coef_t'(40885), tpm_coef_t'(40885), tpm_coef_t'(-11510),
      tpm_coef_t'(4767), tpm_coef_t'(-1742), tpm_coef_t'(368), tpm_coef_t'(0)},
    '{tpm_coef_t'(0), tpm_coef_t'(248), tpm_coef_t'(-1156), tpm_coef_t'(3080),
      tpm_coef_t'(-7011), tpm_coef_t'(19371), tpm_coef_t'(58113), tpm_coef_t'(-9816),
      tpm_coef_t'(3764), tpm_coef_t'(-1334), tpm_coef_t'(277), tpm_coef_t'(0)},
    '{tpm_coef_t'(0), tpm_coef_t'(0), tpm_coef_t'(0), tpm_coef_t'(0),
      tpm_coef_t'(0), tpm_coef_t'(0), tpm_coef_t'(65536), tpm_coef_t'(0),
      tpm_coef_t'(0), tpm_coef_t'(0), tpm_coef_t'(0), tpm_coef_t'(0)},
    '{tpm_coef_t'(0), tpm_coef_t'(-234), tpm_coef_t'(1062), tpm_coef_t'(-2714),
      tpm_coef_t'(5680), tpm_coef_t'(-12107), tpm_coef_t'(60534), tpm_coef_t'(17041),
      tpm_coef_t'(-5041), tpm_coef_t'(1642), tpm_coef_t'(-327), tpm_coef_t'(0)}
  };

  typedef struct packed {
    logic     contrib;
    logic     frozen;
    tpm_mag_t raw_left;
    tpm_mag_t raw_right;
  } tpm_ctl_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } tpm_lane_en_t;

  typedef struct packed {
    logic s5;
    logic s6_load;
  } tpm_merge_en_t;

endpackage

// File: hw/rtl/tpm_if.sv
// Frame and peak channel interfaces of the true-peak meter.
interface tpm_in_if;
  logic                 valid;
  logic                 ready;
  tpm_pkg::tpm_kind_t   kind;
  tpm_pkg::tpm_sample_t left_sample;
  tpm_pkg::tpm_sample_t right_sample;

  modport source (output valid, kind, left_sample, right_sample, input ready);
  modport sink   (input valid, kind, left_sample, right_sample, output ready);
endinterface

interface tpm_out_if;
  logic              valid;
  logic              ready;
  tpm_pkg::tpm_mag_t peak_magnitude;
  logic              frozen;

  modport source (output valid, peak_magnitude, frozen, input ready);
  modport sink   (input valid, peak_magnitude, frozen, output ready);
endinterface

// File: hw/rtl/tpm_front.sv
// Input stage: mode register, freeze flag and per-channel sample history.
module tpm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write_enable,
  input  logic                 cfg_write_data,
  input  logic                 accept,
  input  tpm_pkg::tpm_kind_t   kind,
  input  tpm_pkg::tpm_sample_t left_sample,
  input  tpm_pkg::tpm_sample_t right_sample,
  output tpm_pkg::tpm_sample_t hist [tpm_pkg::CHANNELS][tpm_pkg::TAPS_PER_PHASE],
  output tpm_pkg::tpm_ctl_t    ctl
);
  import tpm_pkg::*;

  logic        mono;
  logic        frozen;
  logic        take;
  logic        is_finish;
  tpm_sample_t right_eff;

  function automatic tpm_mag_t mag_of(input tpm_sample_t s);
    mag_of = s[SAMPLE_BITS-1] ? tpm_mag_t'(~s + tpm_sample_t'(1)) : tpm_mag_t'(s);
  endfunction

  always_comb begin
    is_finish = (kind == KIND_FINISH);
    take      = accept && !is_finish && !frozen;
    right_eff = mono ? left_sample : right_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mono <= 1'b0;
    end else if (cfg_write_enable) begin
      mono <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frozen <= 1'b0;
    end else if (accept && is_finish) begin
      frozen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int n = 0; n < TAPS_PER_PHASE; n++) begin
          hist[c][n] <= '0;
        end
      end
    end else if (take) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int n = 0; n < TAPS_PER_PHASE - 1; n++) begin
          hist[c][n] <= hist[c][n+1];
        end
      end
      hist[0][TAPS_PER_PHASE-1] <= left_sample;
      hist[1][TAPS_PER_PHASE-1] <= right_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl.contrib   <= take;
      ctl.frozen    <= frozen || is_finish;
      ctl.raw_left  <= mag_of(left_sample);
      ctl.raw_right <= mag_of(right_eff);
    end
  end

`ifndef SYNTHESIS
  a_frozen_sticky: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(frozen)) |-> frozen)
    else $error("freeze flag cleared without reset");

  a_hist_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && (frozen || is_finish)) |=>
      (hist[0][TAPS_PER_PHASE-1] == $past(hist[0][TAPS_PER_PHASE-1])))
    else $error("history advanced on an ignored transaction");
`endif

endmodule

// File: hw/rtl/tpm_lane.sv
// One interpolation lane: products, grouped sums, total, rounded magnitude.
module tpm_lane (
  input  logic                   clk,
  input  tpm_pkg::tpm_lane_en_t  en,
  input  tpm_pkg::tpm_sample_t   taps  [tpm_pkg::TAPS_PER_PHASE],
  input  tpm_pkg::tpm_coef_row_t coefs,
  output tpm_pkg::tpm_mag_t      mag
);
  import tpm_pkg::*;

  tpm_prod_t             prod [TAPS_PER_PHASE];
  tpm_acc_t              gsum [NGROUPS];
  tpm_acc_t              gsum_next [NGROUPS];
  tpm_acc_t              acc;
  tpm_acc_t              acc_next;
  logic [ACC_BITS-1:0]   rounded;
  logic [ACC_BITS-1:0]   scaled;
  tpm_mag_t              mag_next;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int n = 0; n < TAPS_PER_PHASE; n++) begin
        prod[n] <= PROD_BITS'(taps[n]) * PROD_BITS'(coefs[n]);
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      gsum_next[g] = '0;
      for (int k = 0; k < GROUP_TAPS; k++) begin
        if (g * GROUP_TAPS + k < TAPS_PER_PHASE) begin
          gsum_next[g] = gsum_next[g] + ACC_BITS'(prod[g * GROUP_TAPS + k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      gsum <= gsum_next;
    end
  end

  always_comb begin
    acc_next = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      acc_next = acc_next + gsum[g];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      acc <= acc_next;
    end
  end

  // round the magnitude half away from zero, then saturate
  always_comb begin
    rounded = acc[ACC_BITS-1] ? (~acc + ROUND_HALF_UP) : (acc + ROUND_HALF);
    scaled  = rounded >> COEF_FRAC;
    if (|scaled[ACC_BITS-1:SAMPLE_BITS]) begin
      mag_next = '1;
    end else begin
      mag_next = scaled[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      mag <= mag_next;
    end
  end

endmodule

// File: hw/rtl/tpm_merge.sv
// Merge stage: per-frame maximum over lanes and raw samples, running peak.
module tpm_merge (
  input  logic                  clk,
  input  logic                  rst,
  input  tpm_pkg::tpm_merge_en_t en,
  input  tpm_pkg::tpm_ctl_t     ctl,
  input  tpm_pkg::tpm_mag_t     lane_mag [tpm_pkg::CHANNELS][tpm_pkg::PHASES],
  output tpm_pkg::tpm_mag_t     peak,
  output logic                  frozen
);
  import tpm_pkg::*;

  tpm_mag_t left_max_next;
  tpm_mag_t right_max_next;
  tpm_mag_t left_max;
  tpm_mag_t right_max;
  tpm_mag_t pick;
  logic     contrib;
  logic     frozen_q;

  always_comb begin
    left_max_next  = ctl.raw_left;
    right_max_next = ctl.raw_right;
    for (int p = 0; p < PHASES; p++) begin
      if (lane_mag[0][p] > left_max_next) begin
        left_max_next = lane_mag[0][p];
      end
      if (lane_mag[1][p] > right_max_next) begin
        right_max_next = lane_mag[1][p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s5) begin
      left_max  <= left_max_next;
      right_max <= right_max_next;
      contrib   <= ctl.contrib;
      frozen_q  <= ctl.frozen;
    end
  end

  assign pick = (left_max > right_max) ? left_max : right_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak   <= '0;
      frozen <= 1'b0;
    end else if (en.s6_load) begin
      frozen <= frozen_q;
      if (contrib && (pick > peak)) begin
        peak <= pick;
      end
    end
  end

`ifndef SYNTHESIS
  a_peak_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (peak >= $past(peak)))
    else $error("running peak decreased");

  a_peak_covers: assert property (@(posedge clk) disable iff (rst)
    (en.s6_load && contrib) |=> (peak >= $past(pick)))
    else $error("running peak below frame maximum");
`endif

endmodule

// File: hw/rtl/oversampled_true_peak_meter.sv
// Top level of the 4x oversampled stereo true-peak meter.
//
//   channel    dir   kind        payload
//   frames     in    valid/ready kind, left_sample, right_sample
//   peaks      out   valid/ready peak_magnitude, frozen
//   cfg_write  in    enable      cfg_write_data (mono_input)
//
// One frame per cycle while peaks is not stalled; a frame's result passes
// through the 7-stage pipeline: history, products, grouped sums,
// total, rounded magnitude, per-channel maximum, running peak.
// Reset (rst, synchronous) clears the history, the peak, the freeze flag and mono.
// A stall on peaks fills empty stages first; frames.ready drops once all are full.
module oversampled_true_peak_meter (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write_enable,
  input  logic            cfg_write_data,
  tpm_in_if.sink          frames,
  tpm_out_if.source       peaks
);
  import tpm_pkg::*;

  localparam int NSTAGES = LANE_STAGES + 3;

  logic [NSTAGES-1:0] vld;
  logic [NSTAGES-1:0] load;
  logic               accept;
  tpm_sample_t        hist [CHANNELS][TAPS_PER_PHASE];
  tpm_ctl_t           ctl0;
  tpm_ctl_t           ctl_q [LANE_STAGES];
  tpm_lane_en_t       lane_en;
  tpm_merge_en_t      merge_en;
  tpm_mag_t           lane_mag [CHANNELS][PHASES];

  always_comb begin
    load[NSTAGES-1] = !vld[NSTAGES-1] || peaks.ready;
    for (int i = NSTAGES - 2; i >= 0; i--) begin
      load[i] = !vld[i] || load[i+1];
    end
  end

  assign frames.ready = load[0];
  assign accept       = frames.valid && load[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) begin
        vld[0] <= frames.valid;
      end
      for (int i = 1; i < NSTAGES; i++) begin
        if (load[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      ctl_q[0] <= ctl0;
    end
    for (int i = 1; i < LANE_STAGES; i++) begin
      if (load[i+1]) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  always_comb begin
    lane_en.s1       = load[1];
    lane_en.s2       = load[2];
    lane_en.s3       = load[3];
    lane_en.s4       = load[4];
    merge_en.s5      = load[5];
    merge_en.s6_load = load[6] && vld[5];
  end

  tpm_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .accept           (accept),
    .kind             (frames.kind),
    .left_sample      (frames.left_sample),
    .right_sample     (frames.right_sample),
    .hist             (hist),
    .ctl              (ctl0)
  );

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    for (genvar p = 0; p < PHASES; p++) begin : g_ph
      tpm_lane u_lane (
        .clk   (clk),
        .en    (lane_en),
        .taps  (hist[c]),
        .coefs (COEF_TABLE[p]),
        .mag   (lane_mag[c][p])
      );
    end
  end

  tpm_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .en       (merge_en),
    .ctl      (ctl_q[LANE_STAGES-1]),
    .lane_mag (lane_mag),
    .peak     (peaks.peak_magnitude),
    .frozen   (peaks.frozen)
  );

  assign peaks.valid = vld[NSTAGES-1];

endmodule
